// ===== src/biq_pkg.sv =====
package biq_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 20;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_FEED_0 = 3'd0;
    localparam logic [2:0] REG_FEED_1 = 3'd1;
    localparam logic [2:0] REG_FEED_2 = 3'd2;
    localparam logic [2:0] REG_BACK_1 = 3'd3;
    localparam logic [2:0] REG_BACK_2 = 3'd4;

    localparam logic signed [COEF_BITS-1:0] FEED_0_RESET = 20'sd262144;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;

    typedef struct packed {
        t_coef feed_coef_0;
        t_coef feed_coef_1;
        t_coef feed_coef_2;
        t_coef back_coef_1;
        t_coef back_coef_2;
    } t_coefs;

    typedef struct packed {
        t_sample    sample_in;
        logic [0:0] channel;
    } t_in_word;

    typedef struct packed {
        t_sample    sample_out;
        logic       clipped;
    } t_out_word;

    // One history entry per channel.
    typedef struct packed {
        t_sample y2;
        t_sample y1;
        t_sample x2;
        t_sample x1;
    } t_hist;

endpackage

// ===== src/biq_cfg.sv =====
module biq_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [biq_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [biq_pkg::DATA_BITS-1:0]     pwdata,
    output logic [biq_pkg::DATA_BITS-1:0]     prdata,
    output logic                              pready,
    output biq_pkg::t_coefs                   o_coefs
);

    biq_pkg::t_coefs r_coefs;
    biq_pkg::t_coef  wr_coef;
    biq_pkg::t_coef  rd_coef;

    assign wr_coef = pwdata[biq_pkg::COEF_BITS-1:0];
    assign pready  = 1'b1;
    assign o_coefs = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.feed_coef_0 <= biq_pkg::FEED_0_RESET;
            r_coefs.feed_coef_1 <= '0;
            r_coefs.feed_coef_2 <= '0;
            r_coefs.back_coef_1 <= '0;
            r_coefs.back_coef_2 <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                biq_pkg::REG_FEED_0: r_coefs.feed_coef_0 <= wr_coef;
                biq_pkg::REG_FEED_1: r_coefs.feed_coef_1 <= wr_coef;
                biq_pkg::REG_FEED_2: r_coefs.feed_coef_2 <= wr_coef;
                biq_pkg::REG_BACK_1: r_coefs.back_coef_1 <= wr_coef;
                biq_pkg::REG_BACK_2: r_coefs.back_coef_2 <= wr_coef;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            biq_pkg::REG_FEED_0: rd_coef = r_coefs.feed_coef_0;
            biq_pkg::REG_FEED_1: rd_coef = r_coefs.feed_coef_1;
            biq_pkg::REG_FEED_2: rd_coef = r_coefs.feed_coef_2;
            biq_pkg::REG_BACK_1: rd_coef = r_coefs.back_coef_1;
            biq_pkg::REG_BACK_2: rd_coef = r_coefs.back_coef_2;
            default:             rd_coef = '0;
        endcase
    end

    assign prdata = biq_pkg::DATA_BITS'(rd_coef);

endmodule

// ===== src/biq_hist.sv =====
module biq_hist #(
    parameter int NUM_CHANNELS = 2,
    parameter int CH_AW        = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [CH_AW-1:0]   i_rd_addr,
    output biq_pkg::t_hist     o_rd_data,
    input  logic               i_wr_en,
    input  logic [CH_AW-1:0]   i_wr_addr,
    input  biq_pkg::t_hist     i_wr_data
);

    biq_pkg::t_hist            r_mem [NUM_CHANNELS];
    biq_pkg::t_hist            r_rd_data;
    logic                      r_rd_hit;
    logic [NUM_CHANNELS-1:0]   r_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // An entry never written since reset reads as zero history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_rd_hit  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

// ===== src/biq_pipe.sv =====
module biq_pipe #(
    parameter int NUM_CHANNELS   = 2,
    parameter int COEF_FRAC_BITS = 18,
    parameter int CH_AW          = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  biq_pkg::t_coefs      i_coefs,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  biq_pkg::t_in_word    i_in_data,
    output logic                 o_rd_en,
    output logic [CH_AW-1:0]     o_rd_addr,
    input  biq_pkg::t_hist       i_rd_data,
    output logic                 o_wr_en,
    output logic [CH_AW-1:0]     o_wr_addr,
    output biq_pkg::t_hist       o_wr_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output biq_pkg::t_out_word   o_out_data
);

    localparam int SB = biq_pkg::SAMPLE_BITS;
    localparam int PW = biq_pkg::COEF_BITS + SB;
    localparam int SW = PW + 3;
    localparam logic [CH_AW-1:0]      CH_LAST = CH_AW'(NUM_CHANNELS - 1);
    localparam logic signed [SW-1:0]  RND     = SW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SW-1:0]  SMAX    = (SW'(1) << (SB - 1)) - SW'(1);
    localparam logic signed [SW-1:0]  SMIN    = ~SMAX;

    // Stage valids and the output register valid.
    logic r_v1, r_v2, r_v3, r_ov;
    logic out_free, mv1, mv2, mv3, s1_free, s2_free, s3_free;
    logic hazard, accept;
    logic [CH_AW-1:0] ch_ext, ch_in;

    // Stage 1: sample, with history arriving from memory.
    logic [CH_AW-1:0]         r_ch1;
    biq_pkg::t_sample         r_x_s1;
    logic signed [PW-1:0]     n_p0, n_p1, n_p2, n_p3, n_p4;

    // Stage 2: products.
    logic [CH_AW-1:0]         r_ch2;
    biq_pkg::t_sample         r_x_s2, r_xd_s2, r_yd_s2;
    logic signed [PW-1:0]     r_p0, r_p1, r_p2, r_p3, r_p4;
    logic signed [SW-1:0]     n_sum;

    // Stage 3: exact sum.
    logic [CH_AW-1:0]         r_ch3;
    biq_pkg::t_sample         r_x_s3, r_xd_s3, r_yd_s3;
    logic signed [SW-1:0]     r_sum;
    logic signed [SW-1:0]     rounded;
    biq_pkg::t_sample         n_y;
    logic                     n_clip;

    biq_pkg::t_out_word       r_out;

    assign out_free = !r_ov || !i_out_stall;
    assign mv3      = r_v3 && out_free;
    assign s3_free  = !r_v3 || mv3;
    assign mv2      = r_v2 && s3_free;
    assign s2_free  = !r_v2 || mv2;
    assign mv1      = r_v1 && s2_free;
    assign s1_free  = !r_v1 || mv1;

    assign ch_ext = CH_AW'(i_in_data.channel);
    assign ch_in  = (ch_ext >= CH_LAST) ? CH_LAST : ch_ext;

    // A word waits while its channel is still in flight, since the history
    // in memory is only current once that earlier word has been written back.
    assign hazard = (r_v1 && r_ch1 == ch_in) || (r_v2 && r_ch2 == ch_in)
                 || (r_v3 && r_ch3 == ch_in);
    assign o_in_stall = !s1_free || hazard;
    assign accept     = i_in_valid && !o_in_stall;

    assign o_rd_en   = accept;
    assign o_rd_addr = ch_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= accept;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (s3_free) begin
                r_v3 <= r_v2;
            end
            if (out_free) begin
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch1  <= ch_in;
            r_x_s1 <= i_in_data.sample_in;
        end
    end

    always_comb begin
        n_p0 = i_coefs.feed_coef_0 * r_x_s1;
        n_p1 = i_coefs.feed_coef_1 * i_rd_data.x1;
        n_p2 = i_coefs.feed_coef_2 * i_rd_data.x2;
        n_p3 = i_coefs.back_coef_1 * i_rd_data.y1;
        n_p4 = i_coefs.back_coef_2 * i_rd_data.y2;
    end

    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_ch2   <= r_ch1;
            r_x_s2  <= r_x_s1;
            r_xd_s2 <= i_rd_data.x1;
            r_yd_s2 <= i_rd_data.y1;
            r_p0    <= n_p0;
            r_p1    <= n_p1;
            r_p2    <= n_p2;
            r_p3    <= n_p3;
            r_p4    <= n_p4;
        end
    end

    assign n_sum = SW'(r_p0) + SW'(r_p1) + SW'(r_p2) - SW'(r_p3) - SW'(r_p4);

    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_ch3   <= r_ch2;
            r_x_s3  <= r_x_s2;
            r_xd_s3 <= r_xd_s2;
            r_yd_s3 <= r_yd_s2;
            r_sum   <= n_sum;
        end
    end

    // Round half up, then saturate to the sample range.
    always_comb begin
        rounded = (r_sum + RND) >>> COEF_FRAC_BITS;
        n_clip  = 1'b0;
        n_y     = rounded[SB-1:0];
        if (rounded > SMAX) begin
            n_y    = SMAX[SB-1:0];
            n_clip = 1'b1;
        end else if (rounded < SMIN) begin
            n_y    = SMIN[SB-1:0];
            n_clip = 1'b1;
        end
    end

    assign o_wr_en      = mv3;
    assign o_wr_addr    = r_ch3;
    assign o_wr_data.x1 = r_x_s3;
    assign o_wr_data.x2 = r_xd_s3;
    assign o_wr_data.y1 = n_y;
    assign o_wr_data.y2 = r_yd_s3;

    always_ff @(posedge i_clk) begin
        if (mv3) begin
            r_out.sample_out <= n_y;
            r_out.clipped    <= n_clip;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_one_per_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_v1 && r_v2 && r_ch1 == r_ch2) || (r_v1 && r_v3 && r_ch1 == r_ch3)
          || (r_v2 && r_v3 && r_ch2 == r_ch3)))
        else $error("two words of one channel in flight");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_v1)
        else $error("accepted word lost at stage one");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.clipped) |->
        (o_out_data.sample_out == SMAX[SB-1:0] || o_out_data.sample_out == SMIN[SB-1:0]))
        else $error("clipped word not at a limit");

    a_write_on_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv3 |=> o_out_valid)
        else $error("written-back word missing at output");

endmodule

// ===== src/biquad_iir_filter_multichannel.sv =====
// An accepted word passes through stage one, stage two, stage three and the output
// register. Throughput: one word per cycle while the output is not stalled and each
// word's channel differs from the words in the three arithmetic stages; a word on a
// channel still in flight waits for its write-back to the history memory, so a channel
// takes no new word before its previous word has been written back.
// Reset: synchronous, active low; sets b0 to 1.0 and the other coefficients to zero,
// marks every channel's history as zero and empties the pipeline.
module biquad_iir_filter_multichannel #(
    parameter int NUM_CHANNELS   = 2,
    parameter int COEF_FRAC_BITS = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [biq_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [biq_pkg::DATA_BITS-1:0]  pwdata,
    output logic [biq_pkg::DATA_BITS-1:0]  prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  biq_pkg::t_in_word              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output biq_pkg::t_out_word             o_out_data
);

    localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    biq_pkg::t_coefs   coefs;
    biq_pkg::t_hist    rd_data;
    biq_pkg::t_hist    wr_data;
    logic              rd_en;
    logic              wr_en;
    logic [CH_AW-1:0]  rd_addr;
    logic [CH_AW-1:0]  wr_addr;

    biq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (coefs)
    );

    biq_hist #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CH_AW        (CH_AW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    biq_pipe #(
        .NUM_CHANNELS   (NUM_CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .CH_AW          (CH_AW)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coefs     (coefs),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
